// File: src/slu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slu_pkg
// Shared types and constants for the string literal unescaper.
// ----------------------------------------------------------------------------
package slu_pkg;

   localparam int SLU_QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_OUT,
      PH_LIT,
      PH_ESC,
      PH_DIG,
      PH_UTF
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_UNKNOWN,
      ERR_TRUNC
   } err_type;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   typedef struct packed {
      logic          code_en;
      logic [31:0]   code;
      err_type       code_err;
      logic          tail_en;
      logic [7:0]    tail_byte;
      logic          tail_has;
      logic          tail_end;
      err_type       tail_err;
   } job_type;

endpackage

// File: src/slu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slu_front
// Classify source bytes, track literal/escape/UTF-8 state, issue output jobs.
// ----------------------------------------------------------------------------
module slu_front import slu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] src_byte,
   output logic       job_valid,
   output job_type    job
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  digits_left_ff, digits_left_in;
   logic        radix_hex_ff, radix_hex_in;
   logic [31:0] code_value_ff, code_value_in;
   logic [1:0]  cont_left_ff, cont_left_in;

   phase_type   p_phase;
   logic        p_tail_en, p_has, p_end, p_lead;
   logic [31:0] p_code;
   logic [1:0]  p_cont;

   logic        dig_ok;
   logic [3:0]  dig_val;
   logic [31:0] dig_code;
   logic [3:0]  dig_left;
   logic [31:0] utf_code;
   logic [1:0]  utf_left;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_OUT;
         digits_left_ff <= '0;
         radix_hex_ff   <= 1'b0;
         code_value_ff  <= '0;
         cont_left_ff   <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         digits_left_ff <= digits_left_in;
         radix_hex_ff   <= radix_hex_in;
         code_value_ff  <= code_value_in;
         cont_left_ff   <= cont_left_in;
      end
   end

   // plain literal byte
   always_comb begin
      p_phase   = PH_LIT;
      p_tail_en = 1'b0;
      p_has     = 1'b0;
      p_end     = 1'b0;
      p_lead    = 1'b0;
      p_code    = '0;
      p_cont    = '0;
      if (src_byte == CH_QUOTE) begin
         p_phase   = PH_OUT;
         p_tail_en = 1'b1;
         p_end     = 1'b1;
      end else if (src_byte == CH_BACKSLASH) begin
         p_phase = PH_ESC;
      end else if (!src_byte[7]) begin
         p_tail_en = 1'b1;
         p_has     = 1'b1;
      end else begin
         p_phase = PH_UTF;
         p_lead  = 1'b1;
         if (src_byte[7:5] == 3'b110) begin
            p_code = {27'd0, src_byte[4:0]};
            p_cont = 2'd1;
         end else if (src_byte[7:4] == 4'b1110) begin
            p_code = {28'd0, src_byte[3:0]};
            p_cont = 2'd2;
         end else begin
            p_code = {29'd0, src_byte[2:0]};
            p_cont = 2'd3;
         end
      end
   end

   // escape digit and UTF-8 continuation decode
   always_comb begin
      dig_ok  = 1'b0;
      dig_val = '0;
      if (src_byte inside {["0":"7"]}) begin
         dig_ok  = 1'b1;
         dig_val = src_byte[3:0];
      end else if (radix_hex_ff && (src_byte inside {["8":"9"]})) begin
         dig_ok  = 1'b1;
         dig_val = src_byte[3:0];
      end else if (radix_hex_ff && (src_byte inside {["a":"f"], ["A":"F"]})) begin
         dig_ok  = 1'b1;
         dig_val = src_byte[3:0] + 4'd9;
      end
      dig_code = radix_hex_ff ? {code_value_ff[27:0], dig_val}
                              : {code_value_ff[28:0], dig_val[2:0]};
      dig_left = digits_left_ff - 4'd1;
      utf_code = {code_value_ff[25:0], src_byte[5:0]};
      utf_left = cont_left_ff - 2'd1;
   end

   always_comb begin
      phase_in       = phase_ff;
      digits_left_in = digits_left_ff;
      radix_hex_in   = radix_hex_ff;
      code_value_in  = code_value_ff;
      cont_left_in   = cont_left_ff;
      job            = '0;
      job.code_err   = ERR_NONE;
      job.tail_err   = ERR_NONE;

      case (phase_ff)
         PH_OUT: begin
            if (src_byte == CH_QUOTE) begin
               phase_in = PH_LIT;
            end
         end
         PH_LIT: begin
            phase_in      = p_phase;
            job.tail_en   = p_tail_en;
            job.tail_byte = p_has ? src_byte : 8'd0;
            job.tail_has  = p_has;
            job.tail_end  = p_end;
            if (p_lead) begin
               code_value_in = p_code;
               cont_left_in  = p_cont;
            end
         end
         PH_ESC: begin
            phase_in      = PH_LIT;
            job.tail_has  = 1'b1;
            case (src_byte)
               "a": begin job.tail_en = 1'b1; job.tail_byte = 8'h07; end
               "b": begin job.tail_en = 1'b1; job.tail_byte = 8'h08; end
               "f": begin job.tail_en = 1'b1; job.tail_byte = 8'h0C; end
               "n": begin job.tail_en = 1'b1; job.tail_byte = 8'h0A; end
               "r": begin job.tail_en = 1'b1; job.tail_byte = 8'h0D; end
               "t": begin job.tail_en = 1'b1; job.tail_byte = 8'h09; end
               "v": begin job.tail_en = 1'b1; job.tail_byte = 8'h0B; end
               "x", "u", "U": begin
                  phase_in       = PH_DIG;
                  radix_hex_in   = 1'b1;
                  code_value_in  = '0;
                  digits_left_in = (src_byte == "x") ? 4'd2 :
                                   (src_byte == "u") ? 4'd4 : 4'd8;
               end
               default: begin
                  if (src_byte inside {["0":"7"]}) begin
                     phase_in       = PH_DIG;
                     radix_hex_in   = 1'b0;
                     digits_left_in = 4'd2;
                     code_value_in  = {29'd0, src_byte[2:0]};
                  end else if (src_byte inside {["8":"9"]}) begin
                     job.code_en   = 1'b1;
                     job.code_err  = ERR_TRUNC;
                     job.tail_en   = 1'b1;
                     job.tail_byte = src_byte;
                  end else begin
                     job.tail_en   = 1'b1;
                     job.tail_byte = src_byte;
                     job.tail_err  = (src_byte == CH_QUOTE || src_byte == "'" ||
                                      src_byte == "?" || src_byte == CH_BACKSLASH)
                                     ? ERR_NONE : ERR_UNKNOWN;
                  end
               end
            endcase
         end
         PH_DIG: begin
            if (dig_ok) begin
               code_value_in  = dig_code;
               digits_left_in = dig_left;
               if (dig_left == 4'd0) begin
                  job.code_en = 1'b1;
                  job.code    = dig_code;
                  phase_in    = PH_LIT;
               end
            end else begin
               job.code_en    = 1'b1;
               job.code       = code_value_ff;
               job.code_err   = ERR_TRUNC;
               digits_left_in = '0;
               phase_in       = p_phase;
               job.tail_en    = p_tail_en;
               job.tail_byte  = p_has ? src_byte : 8'd0;
               job.tail_has   = p_has;
               job.tail_end   = p_end;
               if (p_lead) begin
                  code_value_in = p_code;
                  cont_left_in  = p_cont;
               end
            end
         end
         PH_UTF: begin
            if (src_byte[7:6] != 2'b10) begin
               job.tail_en  = 1'b1;
               job.tail_has = 1'b1;
               cont_left_in = '0;
               phase_in     = PH_LIT;
            end else begin
               code_value_in = utf_code;
               cont_left_in  = utf_left;
               if (utf_left == 2'd0) begin
                  job.code_en = 1'b1;
                  job.code    = utf_code;
                  phase_in    = PH_LIT;
               end
            end
         end
         default: begin
            phase_in = PH_OUT;
         end
      endcase

      job_valid = job.code_en | job.tail_en;
   end

endmodule

// File: src/slu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slu_queue
// Small job queue between the byte classifier and the output serializer.
// ----------------------------------------------------------------------------
module slu_queue import slu_pkg::*; #(
   parameter int DEPTH = SLU_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type        mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign head_job = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);

endmodule

// File: src/slu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slu_back
// Expand each job into UTF-8 result bytes, one per cycle while the receiver is
// ready, into the output register.
// ----------------------------------------------------------------------------
module slu_back import slu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [3:0] rsp_tuser,   // has_byte, literal_end, error_code[1:0]
   output logic       rsp_tlast    // last
);

   logic [2:0] step_ff, step_in;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       has_ff, end_ff, last_ff;
   err_type    err_ff;

   logic       load;
   logic [2:0] ncode, total;
   logic [1:0] pos;
   logic [7:0] r_byte;
   logic       r_has, r_end, r_last;
   err_type    r_err;
   logic [31:0] c;

   assign c    = head_job.code;
   assign load = !valid_ff || rsp_tready;

   always_comb begin
      if (!head_job.code_en)     ncode = 3'd0;
      else if (c < 32'h80)       ncode = 3'd1;
      else if (c < 32'h800)      ncode = 3'd2;
      else if (c < 32'h10000)    ncode = 3'd3;
      else                       ncode = 3'd4;
      total = ncode + {2'd0, head_job.tail_en};
      pos   = 2'(ncode - 3'd1 - step_ff);

      r_has = 1'b1;
      r_end = 1'b0;
      r_err = ERR_NONE;
      if (step_ff < ncode) begin
         if (step_ff == 3'd0) begin
            r_err = head_job.code_err;
            case (ncode)
               3'd1:    r_byte = c[7:0];
               3'd2:    r_byte = 8'hC0 | c[13:6];
               3'd3:    r_byte = 8'hE0 | c[19:12];
               default: r_byte = 8'hF0 | c[25:18];
            endcase
         end else begin
            case (pos)
               2'd0:    r_byte = {2'b10, c[5:0]};
               2'd1:    r_byte = {2'b10, c[11:6]};
               default: r_byte = {2'b10, c[17:12]};
            endcase
         end
      end else begin
         r_byte = head_job.tail_byte;
         r_has  = head_job.tail_has;
         r_end  = head_job.tail_end;
         r_err  = head_job.tail_err;
      end
      r_last = (step_ff + 3'd1 == total);

      pop     = load && !empty && r_last;
      step_in = step_ff;
      if (load && !empty) begin
         step_in = r_last ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (load) begin
            valid_ff <= !empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && !empty) begin
         byte_ff <= r_byte;
         has_ff  <= r_has;
         end_ff  <= r_end;
         err_ff  <= r_err;
         last_ff <= r_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {err_ff, end_ff, has_ff};
   assign rsp_tlast  = last_ff;

endmodule

// File: src/string_literal_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_unescape_utf8
// Unescape a C string literal byte stream into UTF-8 value bytes.
// ----------------------------------------------------------------------------
// One source byte is accepted per cycle while the job queue is not full. Each
// byte yields zero to five result transactions; the serializer delivers one
// result per cycle while the receiver is ready. Jobs wait in a queue of
// QUEUE_DEPTH entries, and the input stalls only when that queue is full.
// A closing quote gives a result with has_byte low and literal_end high;
// error_code rides on the first result of the affected code point.
// ----------------------------------------------------------------------------
module string_literal_unescape_utf8 import slu_pkg::*; #(
   parameter int QUEUE_DEPTH = SLU_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // source_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic [3:0] rsp_tuser,   // has_byte, literal_end, error_code[1:0]
   output logic       rsp_tlast    // last
);

   logic    accept, job_valid, q_empty, q_full, q_pop;
   job_type job, head_job;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   slu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .src_byte  (req_tdata),
      .job_valid (job_valid),
      .job       (job)
   );

   slu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && job_valid),
      .push_job (job),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   slu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .empty      (q_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: src/slu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slu_checker
// Port-level checks on the result stream of the unescaper.
// ----------------------------------------------------------------------------
module slu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [3:0] rsp_tuser,
   input logic       rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_end_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tlast &&
      rsp_tuser[3:2] == 2'd0)
      else $error("literal end result malformed");

   a_nobyte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tuser[1] && rsp_tdata == 8'd0)
      else $error("empty result without literal end");

   a_errcode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[3:2] != 2'd3)
      else $error("undefined error code");

endmodule

bind string_literal_unescape_utf8 slu_checker u_slu_checker (.*);

// File: sim/string_literal_unescape_utf8_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_unescape_utf8_tb
// Self-checking bench for the C string literal unescaper.
// ----------------------------------------------------------------------------
// A directed table covers ignored bytes outside a literal, simple and unknown
// escapes, short digit runs, raw and broken UTF-8, and stray lead bytes.
// Random literals follow, built mostly from well-formed escape and UTF-8
// sequences with random content and some noise. A behavioral unescaper
// predicts every result transaction but those of pinned rows. Both ports
// idle and stall in several phases, and one long receiver hold-off lets the job queue fill up.
// ----------------------------------------------------------------------------
module string_literal_unescape_utf8_tb;
   import slu_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_ITEMS  = 350;
   localparam int MAX_PRINTS    = 50;
   localparam int DIRECTED_ROWS = 28;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       literal_end;
      err_type    error_code;
      logic       last;
   } utf8_result_type;

   typedef struct packed {
      logic [7:0]      src;
      logic            pinned;
      logic            pinned_has;
      utf8_result_type pinned_res;
   } source_row_type;

   localparam utf8_result_type NO_RESULT = '0;

   localparam logic [7:0] SIMPLE_ESC [11] = '{
      "a", "b", "f", "n", "r", "t", "v", "'", "?", CH_QUOTE, CH_BACKSLASH
   };

   localparam source_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h00,        1'b1, 1'b0, NO_RESULT},
      '{8'hFF,        1'b1, 1'b0, NO_RESULT},
      '{CH_QUOTE,     1'b1, 1'b0, NO_RESULT},
      '{8'h7F,        1'b1, 1'b1, '{8'h7F, 1'b1, 1'b0, ERR_NONE, 1'b1}},
      '{CH_BACKSLASH, 1'b1, 1'b0, NO_RESULT},
      '{"n",          1'b1, 1'b1, '{8'h0A, 1'b1, 1'b0, ERR_NONE, 1'b1}},
      '{CH_BACKSLASH, 1'b1, 1'b0, NO_RESULT},
      '{"q",          1'b1, 1'b1, '{8'h71, 1'b1, 1'b0, ERR_UNKNOWN, 1'b1}},
      '{CH_BACKSLASH, 1'b1, 1'b0, NO_RESULT},
      '{"9",          1'b0, 1'b0, NO_RESULT},
      '{CH_BACKSLASH, 1'b1, 1'b0, NO_RESULT},
      '{"x",          1'b1, 1'b0, NO_RESULT},
      '{"f",          1'b0, 1'b0, NO_RESULT},
      '{"F",          1'b0, 1'b0, NO_RESULT},
      '{8'hE2,        1'b0, 1'b0, NO_RESULT},
      '{8'h82,        1'b0, 1'b0, NO_RESULT},
      '{8'hAC,        1'b0, 1'b0, NO_RESULT},
      '{8'hC3,        1'b0, 1'b0, NO_RESULT},
      '{CH_QUOTE,     1'b0, 1'b0, NO_RESULT},
      '{8'h80,        1'b0, 1'b0, NO_RESULT},
      '{8'hBF,        1'b0, 1'b0, NO_RESULT},
      '{8'hBF,        1'b0, 1'b0, NO_RESULT},
      '{8'hBF,        1'b0, 1'b0, NO_RESULT},
      '{CH_BACKSLASH, 1'b0, 1'b0, NO_RESULT},
      '{"U",          1'b0, 1'b0, NO_RESULT},
      '{"1",          1'b0, 1'b0, NO_RESULT},
      '{"0",          1'b0, 1'b0, NO_RESULT},
      '{CH_QUOTE,     1'b0, 1'b0, NO_RESULT}
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // source_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // out_byte
   logic [3:0] rsp_tuser;            // has_byte, literal_end, error_code[1:0]
   logic       rsp_tlast;            // last

   source_row_type  source_q [$];
   utf8_result_type utf8_exp_q [$];
   int              literal_items  = 0;
   int              accepted_cnt   = 0;
   int              mismatch_cnt   = 0;
   int              cycle_cnt      = 0;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   logic            hold_req       = 1'b0;

   phase_type   pred_phase = PH_OUT;
   logic [3:0]  pred_left  = '0;
   logic        pred_hex   = 1'b0;
   logic [3:0]  pred_seen  = '0;
   logic [31:0] pred_code  = '0;
   logic [1:0]  pred_cont  = '0;

   string_literal_unescape_utf8 u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_PRINTS) begin
         $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      end
   endtask

   task automatic put_result(input logic [7:0] b, input logic has, input logic fin,
                             input err_type err);
      utf8_result_type r;
      r.out_byte    = b;
      r.has_byte    = has;
      r.literal_end = fin;
      r.error_code  = err;
      r.last        = 1'b0;
      utf8_exp_q.push_back(r);
   endtask

   task automatic put_code_point(input logic [31:0] c, input err_type err);
      if (c < 32'h80) begin
         put_result(c[7:0], 1'b1, 1'b0, err);
      end else if (c < 32'h800) begin
         put_result(8'(32'hC0 | (c >> 6)), 1'b1, 1'b0, err);
         put_result({2'b10, c[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end else if (c < 32'h10000) begin
         put_result(8'(32'hE0 | (c >> 12)), 1'b1, 1'b0, err);
         put_result({2'b10, c[11:6]}, 1'b1, 1'b0, ERR_NONE);
         put_result({2'b10, c[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end else begin
         put_result(8'(32'hF0 | (c >> 18)), 1'b1, 1'b0, err);
         put_result({2'b10, c[17:12]}, 1'b1, 1'b0, ERR_NONE);
         put_result({2'b10, c[11:6]}, 1'b1, 1'b0, ERR_NONE);
         put_result({2'b10, c[5:0]}, 1'b1, 1'b0, ERR_NONE);
      end
   endtask

   task automatic take_plain(input logic [7:0] b);
      pred_phase = PH_LIT;
      if (b == CH_QUOTE) begin
         put_result(8'h00, 1'b0, 1'b1, ERR_NONE);
         pred_phase = PH_OUT;
      end else if (b == CH_BACKSLASH) begin
         pred_phase = PH_ESC;
      end else if (!b[7]) begin
         put_result(b, 1'b1, 1'b0, ERR_NONE);
      end else begin
         if (b[7:5] == 3'b110) begin
            pred_code = {27'd0, b[4:0]};
            pred_cont = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            pred_code = {28'd0, b[3:0]};
            pred_cont = 2'd2;
         end else begin
            pred_code = {29'd0, b[2:0]};
            pred_cont = 2'd3;
         end
         pred_phase = PH_UTF;
      end
   endtask

   task automatic begin_digits(input logic hex, input logic [3:0] count,
                               input logic [31:0] first, input logic [3:0] seen);
      pred_hex   = hex;
      pred_left  = count;
      pred_seen  = seen;
      pred_code  = first;
      pred_phase = PH_DIG;
   endtask

   task automatic unescape_step(input logic [7:0] b);
      int              base;
      logic [4:0]      dv;
      utf8_result_type r;
      base = utf8_exp_q.size();
      case (pred_phase)
         PH_LIT: take_plain(b);
         PH_ESC: begin
            pred_phase = PH_LIT;
            case (b)
               "a": put_result(8'h07, 1'b1, 1'b0, ERR_NONE);
               "b": put_result(8'h08, 1'b1, 1'b0, ERR_NONE);
               "f": put_result(8'h0C, 1'b1, 1'b0, ERR_NONE);
               "n": put_result(8'h0A, 1'b1, 1'b0, ERR_NONE);
               "r": put_result(8'h0D, 1'b1, 1'b0, ERR_NONE);
               "t": put_result(8'h09, 1'b1, 1'b0, ERR_NONE);
               "v": put_result(8'h0B, 1'b1, 1'b0, ERR_NONE);
               "'", "?", CH_QUOTE, CH_BACKSLASH: put_result(b, 1'b1, 1'b0, ERR_NONE);
               "x": begin_digits(1'b1, 4'd2, 32'd0, 4'd0);
               "u": begin_digits(1'b1, 4'd4, 32'd0, 4'd0);
               "U": begin_digits(1'b1, 4'd8, 32'd0, 4'd0);
               default: begin
                  if (b >= "0" && b <= "7") begin
                     begin_digits(1'b0, 4'd2, 32'(b - "0"), 4'd1);
                  end else if (b == "8" || b == "9") begin
                     put_result(8'h00, 1'b1, 1'b0, ERR_TRUNC);
                     take_plain(b);
                  end else begin
                     put_result(b, 1'b1, 1'b0, ERR_UNKNOWN);
                  end
               end
            endcase
         end
         PH_DIG: begin
            dv = 5'd16;
            if (b >= "0" && b <= "7") begin
               dv = 5'(b - "0");
            end else if (pred_hex) begin
               if (b == "8" || b == "9") begin
                  dv = 5'(b - "0");
               end else if (b >= "a" && b <= "f") begin
                  dv = 5'(b - "a" + 8'd10);
               end else if (b >= "A" && b <= "F") begin
                  dv = 5'(b - "A" + 8'd10);
               end
            end
            if (dv < 5'd16) begin
               pred_code = pred_hex ? {pred_code[27:0], dv[3:0]} : {pred_code[28:0], dv[2:0]};
               pred_seen = pred_seen + 4'd1;
               pred_left = pred_left - 4'd1;
               if (pred_left == 4'd0) begin
                  put_code_point(pred_code, ERR_NONE);
                  pred_phase = PH_LIT;
               end
            end else begin
               put_code_point(pred_code, ERR_TRUNC);
               pred_left = 4'd0;
               take_plain(b);
            end
         end
         PH_UTF: begin
            if (b[7:6] != 2'b10) begin
               put_result(8'h00, 1'b1, 1'b0, ERR_NONE);
               pred_cont  = 2'd0;
               pred_phase = PH_LIT;
            end else begin
               pred_code = {pred_code[25:0], b[5:0]};
               pred_cont = pred_cont - 2'd1;
               if (pred_cont == 2'd0) begin
                  put_code_point(pred_code, ERR_NONE);
                  pred_phase = PH_LIT;
               end
            end
         end
         default: begin
            pred_phase = (b == CH_QUOTE) ? PH_LIT : PH_OUT;
         end
      endcase
      if (utf8_exp_q.size() > base) begin
         r = utf8_exp_q.pop_back();
         r.last = 1'b1;
         utf8_exp_q.push_back(r);
      end
   endtask

   task automatic add_source(input logic [7:0] b, input bit counted);
      source_row_type r;
      r = '0;
      r.src = b;
      source_q.push_back(r);
      if (counted) literal_items++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return "0" + 8'(v);
      return ($urandom_range(0, 1) ? "a" : "A") + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] lead_byte(input int conts);
      if (conts == 1) return 8'hC0 | 8'($urandom_range(0, 31));
      if (conts == 2) return 8'hE0 | 8'($urandom_range(0, 15));
      return 8'hF0 | 8'($urandom_range(0, 7));
   endfunction

   task automatic add_literal();
      int         nseg;
      int         n;
      logic [7:0] b;
      add_source(CH_QUOTE, 1'b1);
      nseg = $urandom_range(1, 8);
      repeat (nseg) begin
         case ($urandom_range(0, 11))
            0: begin
               b = 8'($urandom_range(0, 127));
               if (b == CH_QUOTE || b == CH_BACKSLASH) b = "z";
               add_source(b, 1'b1);
            end
            1: begin
               add_source(CH_BACKSLASH, 1'b1);
               add_source(SIMPLE_ESC[$urandom_range(0, 10)], 1'b1);
            end
            2: begin
               add_source(CH_BACKSLASH, 1'b1);
               repeat ($urandom_range(1, 3)) add_source("0" + 8'($urandom_range(0, 7)), 1'b1);
            end
            3: begin
               add_source(CH_BACKSLASH, 1'b1);
               add_source("x", 1'b1);
               n = $urandom_range(0, 4) != 0 ? 2 : $urandom_range(0, 1);
               repeat (n) add_source(hex_char(4'($urandom)), 1'b1);
            end
            4: begin
               add_source(CH_BACKSLASH, 1'b1);
               add_source("u", 1'b1);
               n = $urandom_range(0, 4) != 0 ? 4 : $urandom_range(0, 3);
               repeat (n) add_source(hex_char(4'($urandom)), 1'b1);
            end
            5: begin
               add_source(CH_BACKSLASH, 1'b1);
               add_source("U", 1'b1);
               n = $urandom_range(0, 4) != 0 ? 8 : $urandom_range(0, 7);
               repeat (n) add_source(hex_char(4'($urandom)), 1'b1);
            end
            6: begin
               n = $urandom_range(1, 3);
               add_source(lead_byte(n), 1'b1);
               repeat (n) add_source(8'h80 | 8'($urandom_range(0, 63)), 1'b1);
            end
            7: begin
               n = $urandom_range(1, 3);
               add_source(lead_byte(n), 1'b1);
               repeat ($urandom_range(0, n - 1)) add_source(8'h80 | 8'($urandom_range(0, 63)), 1'b1);
               if ($urandom_range(0, 1)) begin
                  add_source(8'($urandom_range(0, 127)), 1'b1);
               end else begin
                  add_source(8'($urandom_range(8'hC0, 8'hFF)), 1'b1);
               end
            end
            8: begin
               if ($urandom_range(0, 1)) begin
                  add_source(8'($urandom_range(8'h80, 8'hBF)), 1'b1);
               end else begin
                  add_source(8'($urandom_range(8'hF8, 8'hFF)), 1'b1);
               end
               repeat (3) add_source(8'h80 | 8'($urandom_range(0, 63)), 1'b1);
            end
            9: begin
               add_source(CH_BACKSLASH, 1'b1);
               add_source(8'($urandom), 1'b1);
            end
            10: add_source(8'($urandom), 1'b1);
            default: begin
               add_source(CH_BACKSLASH, 1'b1);
               add_source($urandom_range(0, 1) ? "8" : "9", 1'b1);
            end
         endcase
      end
      add_source(CH_QUOTE, 1'b1);
      repeat ($urandom_range(0, 2)) add_source(8'($urandom), 1'b0);
   endtask

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      source_row_type  row;
      utf8_result_type got;
      utf8_result_type want;
      int              base;
      if (!reset && req_tvalid && req_tready) begin
         row  = source_q[accepted_cnt];
         base = utf8_exp_q.size();
         unescape_step(req_tdata);
         if (row.pinned) begin
            while (utf8_exp_q.size() > base) void'(utf8_exp_q.pop_back());
            if (row.pinned_has) utf8_exp_q.push_back(row.pinned_res);
         end
         accepted_cnt++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1], err_type'(rsp_tuser[3:2]), rsp_tlast};
         if (utf8_exp_q.size() == 0) begin
            report_mismatch("unexpected transaction, out_byte", got.out_byte, 0);
         end else begin
            want = utf8_exp_q.pop_front();
            if (got.out_byte != want.out_byte)
               report_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.has_byte != want.has_byte)
               report_mismatch("has_byte", got.has_byte, want.has_byte);
            if (got.literal_end != want.literal_end)
               report_mismatch("literal_end", got.literal_end, want.literal_end);
            if (got.error_code != want.error_code)
               report_mismatch("error_code", got.error_code, want.error_code);
            if (got.last != want.last)
               report_mismatch("last", got.last, want.last);
         end
      end
   end

   // receiver: random backpressure, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      int rand_base;
      int total;
      for (int k = 0; k < DIRECTED_ROWS; k++) source_q.push_back(DIRECTED[k]);
      rand_base = source_q.size();
      while (literal_items < RANDOM_ITEMS) add_literal();
      total = source_q.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < total; i++) begin
         if (i >= rand_base) begin
            case ((i - rand_base) * 4 / (total - rand_base))
               0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
               default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (i == rand_base) hold_req = 1'b1;
         end
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= source_q[i].src;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;

      while (accepted_cnt != total || utf8_exp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/slu_pkg.sv
src/slu_front.sv
src/slu_queue.sv
src/slu_back.sv
src/string_literal_unescape_utf8.sv
src/slu_checker.sv
sim/string_literal_unescape_utf8_tb.sv
